### hdl/mm_pkg.sv
// Shared types, constants and helper functions for the matrix multiply block.
// Used by mm_store, mm_mac and matrix_multiply. No dependencies.
package mm_pkg;

    localparam int MAX_DIM     = 8;
    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int IDX_W       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W       = $clog2(MAX_DIM + 1);
    localparam int PROD_W      = 2 * VALUE_WIDTH;
    localparam int ACC_W       = PROD_W + IDX_W + 1;
    localparam int SHIFT_W     = ACC_W - FRAC_BITS;

    localparam longint VMAX = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;

    // Field widths of the stream items.
    localparam int REQ_W   = 2;
    localparam int POS_W   = 3;
    localparam int ELEM_W  = 32;
    localparam int TDATA_W = 40;

    // Request kinds carried in the input tuser.
    localparam logic [REQ_W-1:0] REQ_LOAD_A  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_B  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;
    localparam logic [CFG_DATA_W-1:0] CFG_DIM_RESET = 4'd8;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [DIM_W-1:0]  t_dim;
    typedef logic signed [VALUE_WIDTH-1:0] t_val;

    // Tag that travels with each multiply-accumulate step.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic fin;
        t_idx row;
        t_idx col;
    } t_tag;

    // Finished dot product leaving the accumulator.
    typedef struct packed {
        logic valid;
        logic last;
        t_idx row;
        t_idx col;
        t_val value;
    } t_res;

    function automatic t_addr mm_addr(input t_idx r, input t_idx c);
        mm_addr = ADDR_W'(32'(r) * MAX_DIM + 32'(c));
    endfunction

    function automatic t_dim clamp_dim(input logic [CFG_DATA_W-1:0] d);
        if (d == '0) begin
            clamp_dim = t_dim'(1);
        end else if (32'(d) > MAX_DIM) begin
            clamp_dim = t_dim'(MAX_DIM);
        end else begin
            clamp_dim = t_dim'(d);
        end
    endfunction

    // Drop the fraction bits (floor) and saturate to the value width.
    function automatic t_val sat_q(input logic signed [ACC_W-1:0] acc);
        logic signed [SHIFT_W-1:0] sh;
        logic signed [SHIFT_W-1:0] hi;
        logic signed [SHIFT_W-1:0] lo;
        sh = SHIFT_W'(acc >>> FRAC_BITS);
        hi = SHIFT_W'(VMAX);
        lo = -hi - SHIFT_W'(1);
        if (sh > hi) begin
            sat_q = t_val'(hi);
        end else if (sh < lo) begin
            sat_q = t_val'(lo);
        end else begin
            sat_q = t_val'(sh);
        end
    endfunction

endpackage

### hdl/mm_store.sv
// Element store for one matrix: single write port, one registered read port.
// Depends on mm_pkg.
module mm_store (
    input  logic          i_clk,
    input  logic          i_we,
    input  mm_pkg::t_addr i_waddr,
    input  mm_pkg::t_val  i_wdata,
    input  logic          i_re,
    input  mm_pkg::t_addr i_raddr,
    output mm_pkg::t_val  o_rdata
);

    mm_pkg::t_val r_mem [mm_pkg::STORE_DEPTH];
    mm_pkg::t_val r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/mm_mac.sv
// Shared multiply-accumulate unit: registered product, then full-precision sum.
// Depends on mm_pkg.
module mm_mac (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  mm_pkg::t_tag i_tag,
    input  mm_pkg::t_val i_a,
    input  mm_pkg::t_val i_b,
    output mm_pkg::t_res o_res
);

    mm_pkg::t_tag r_p_tag;
    mm_pkg::t_tag r_a_tag;
    logic signed [mm_pkg::PROD_W-1:0] r_prod;
    logic signed [mm_pkg::ACC_W-1:0]  r_acc;
    logic signed [mm_pkg::ACC_W-1:0]  n_acc;
    logic signed [mm_pkg::ACC_W-1:0]  w_prod_ext;

    assign w_prod_ext = mm_pkg::ACC_W'(r_prod);

    always_comb begin
        if (r_p_tag.first) begin
            n_acc = w_prod_ext;
        end else begin
            n_acc = r_acc + w_prod_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_tag.valid <= 1'b0;
            r_a_tag.valid <= 1'b0;
        end else if (i_en) begin
            r_p_tag <= i_tag;
            r_a_tag <= r_p_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
            if (r_p_tag.valid) begin
                r_acc <= n_acc;
            end
        end
    end

    always_comb begin
        o_res.valid = r_a_tag.valid && r_a_tag.last;
        o_res.last  = r_a_tag.fin;
        o_res.row   = r_a_tag.row;
        o_res.col   = r_a_tag.col;
        o_res.value = mm_pkg::sat_q(r_acc);
    end

endmodule

### hdl/matrix_multiply.sv
// Matrix multiply top level: sequencer, two element stores, shared MAC, output register.
// Load item: accepted while idle and stored at that edge; next item can follow at once.
// Compute item: the sequencer issues rows*inner*cols MAC steps, one a cycle unless the
// output stalls, and takes no new item until the last step is issued. Output stalls
// freeze the whole MAC pipeline.
// Synchronous active-low reset clears control state; element stores are not cleared.
module matrix_multiply (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input items.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tdata, lowest bit up: row_index[2:0], col_index[5:3], elem_value[37:6], zero pad.
    input  logic [mm_pkg::TDATA_W-1:0]    s_tdata,
    // tuser: req_type[1:0].
    input  logic [mm_pkg::REQ_W-1:0]      s_tuser,
    // Result items.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tdata, lowest bit up: out_row[2:0], out_col[5:3], product_value[37:6], zero pad.
    output logic [mm_pkg::TDATA_W-1:0]    m_tdata,
    // tlast: last_elem.
    output logic                          m_tlast,
    // Configuration writes.
    input  logic                          i_cfg_we,
    input  logic [mm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    // Configuration registers hold the raw written values; they are clamped
    // when a compute item is accepted.
    logic [mm_pkg::CFG_DATA_W-1:0] r_rows_a;
    logic [mm_pkg::CFG_DATA_W-1:0] r_inner_dim;
    logic [mm_pkg::CFG_DATA_W-1:0] r_cols_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= mm_pkg::CFG_DIM_RESET;
            r_inner_dim <= mm_pkg::CFG_DIM_RESET;
            r_cols_b    <= mm_pkg::CFG_DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mm_pkg::CFG_ROWS_A:    r_rows_a    <= i_cfg_data;
                mm_pkg::CFG_INNER_DIM: r_inner_dim <= i_cfg_data;
                mm_pkg::CFG_COLS_B:    r_cols_b    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack the input item.
    logic [mm_pkg::POS_W-1:0]  w_in_row;
    logic [mm_pkg::POS_W-1:0]  w_in_col;
    logic [mm_pkg::ELEM_W-1:0] w_in_elem;
    logic                      w_accept;
    logic                      w_in_range;
    mm_pkg::t_addr             w_waddr;

    assign w_in_row   = s_tdata[2:0];
    assign w_in_col   = s_tdata[5:3];
    assign w_in_elem  = s_tdata[37:6];
    assign w_accept   = s_tvalid && s_tready;
    assign w_in_range = (32'(w_in_row) < mm_pkg::MAX_DIM) && (32'(w_in_col) < mm_pkg::MAX_DIM);
    assign w_waddr    = mm_pkg::ADDR_W'(32'(w_in_row) * mm_pkg::MAX_DIM + 32'(w_in_col));

    // Sequencer: walks i (rows), j (columns), k (inner) with k innermost.
    t_state        r_state, n_state;
    mm_pkg::t_idx  r_i, n_i;
    mm_pkg::t_idx  r_j, n_j;
    mm_pkg::t_idx  r_k, n_k;
    mm_pkg::t_dim  r_nr, n_nr;
    mm_pkg::t_dim  r_nk, n_nk;
    mm_pkg::t_dim  r_nc, n_nc;

    logic          w_stall;
    logic          w_en;
    logic          w_issue;
    logic          w_k_last;
    logic          w_j_last;
    logic          w_i_last;
    mm_pkg::t_tag  w_tag;
    mm_pkg::t_tag  r_s1;

    // The whole MAC pipeline holds while a finished result waits downstream.
    assign w_stall  = m_tvalid && !m_tready;
    assign w_en     = !w_stall;
    assign w_issue  = (r_state == ST_RUN) && w_en;
    assign w_k_last = mm_pkg::DIM_W'(r_k) == (r_nk - mm_pkg::DIM_W'(1));
    assign w_j_last = mm_pkg::DIM_W'(r_j) == (r_nc - mm_pkg::DIM_W'(1));
    assign w_i_last = mm_pkg::DIM_W'(r_i) == (r_nr - mm_pkg::DIM_W'(1));

    assign s_tready = (r_state == ST_IDLE);

    always_comb begin
        w_tag.valid = w_issue;
        w_tag.first = (r_k == '0);
        w_tag.last  = w_k_last;
        w_tag.fin   = w_k_last && w_j_last && w_i_last;
        w_tag.row   = r_i;
        w_tag.col   = r_j;
    end

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_nr    = r_nr;
        n_nk    = r_nk;
        n_nc    = r_nc;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && s_tuser == mm_pkg::REQ_COMPUTE) begin
                    n_state = ST_RUN;
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                    n_nr    = mm_pkg::clamp_dim(r_rows_a);
                    n_nk    = mm_pkg::clamp_dim(r_inner_dim);
                    n_nc    = mm_pkg::clamp_dim(r_cols_b);
                end
            end
            ST_RUN: begin
                if (w_issue) begin
                    if (!w_k_last) begin
                        n_k = r_k + mm_pkg::IDX_W'(1);
                    end else begin
                        n_k = '0;
                        if (!w_j_last) begin
                            n_j = r_j + mm_pkg::IDX_W'(1);
                        end else begin
                            n_j = '0;
                            if (!w_i_last) begin
                                n_i = r_i + mm_pkg::IDX_W'(1);
                            end else begin
                                n_state = ST_IDLE;
                            end
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i  <= n_i;
        r_j  <= n_j;
        r_k  <= n_k;
        r_nr <= n_nr;
        r_nk <= n_nk;
        r_nc <= n_nc;
    end

    // Stage 1: the tag waits alongside the registered store reads.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (w_en) begin
            r_s1 <= w_tag;
        end
    end

    mm_pkg::t_val w_a_data;
    mm_pkg::t_val w_b_data;
    mm_pkg::t_val w_wdata;

    assign w_wdata = mm_pkg::t_val'(w_in_elem[mm_pkg::VALUE_WIDTH-1:0]);

    mm_store u_a_store (
        .i_clk   (i_clk),
        .i_we    (w_accept && w_in_range && s_tuser == mm_pkg::REQ_LOAD_A),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_issue),
        .i_raddr (mm_pkg::mm_addr(r_i, r_k)),
        .o_rdata (w_a_data)
    );

    mm_store u_b_store (
        .i_clk   (i_clk),
        .i_we    (w_accept && w_in_range && s_tuser == mm_pkg::REQ_LOAD_B),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_issue),
        .i_raddr (mm_pkg::mm_addr(r_k, r_j)),
        .o_rdata (w_b_data)
    );

    // Stages 2 and 3: product register and accumulator.
    mm_pkg::t_res w_res;

    mm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (r_s1),
        .i_a     (w_a_data),
        .i_b     (w_b_data),
        .o_res   (w_res)
    );

    // Output register. It loads a finished dot product whenever the pipeline
    // moves; when it moves while holding a result, that result is being taken.
    logic                      r_m_valid;
    logic                      r_m_last;
    logic [mm_pkg::POS_W-1:0]  r_m_row;
    logic [mm_pkg::POS_W-1:0]  r_m_col;
    mm_pkg::t_val              r_m_val;
    logic signed [mm_pkg::ELEM_W-1:0] w_m_val_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_en) begin
            r_m_valid <= w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_res.valid) begin
            r_m_last <= w_res.last;
            r_m_row  <= mm_pkg::POS_W'(w_res.row);
            r_m_col  <= mm_pkg::POS_W'(w_res.col);
            r_m_val  <= w_res.value;
        end
    end

    assign w_m_val_ext = mm_pkg::ELEM_W'(r_m_val);
    assign m_tvalid    = r_m_valid;
    assign m_tlast     = r_m_last;
    assign m_tdata     = {2'b00, w_m_val_ext, r_m_col, r_m_row};

    // A stalled sequencer must not move its counters.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stall && r_state == ST_RUN) |=> ($stable(r_i) && $stable(r_j) && $stable(r_k)))
        else $error("sequencer advanced during an output stall");

    // Issuing the final step of a product ends the run.
    a_fin_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_issue && w_tag.fin) |=> (r_state == ST_IDLE))
        else $error("sequencer kept running after the final step");

    // A new result only appears when the accumulator finished a dot product.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !$past(r_m_valid)) |-> $past(w_res.valid))
        else $error("result item appeared without a finished accumulation");

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the matrix_multiply block: stream stimulus, size writes,
// a built-in product predictor and an in-order result checker.
// Depends on mm_pkg and matrix_multiply from the RTL.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 9;
    localparam int TOTAL_ITEMS    = 380;
    // Cycles allowed after the last result before the sizes change or the run ends.
    localparam int SETTLE_CYCLES  = 16;
    localparam int END_CYCLES     = 60;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    // Codes that the block accepts but that have no meaning of their own.
    localparam logic [mm_pkg::REQ_W-1:0]     REQ_IGNORED = 2'd3;
    localparam logic [mm_pkg::CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;

    // One element of the product as it is expected on the result stream.
    typedef struct packed {
        logic [mm_pkg::POS_W-1:0]  row;
        logic [mm_pkg::POS_W-1:0]  col;
        logic [mm_pkg::ELEM_W-1:0] value;
        logic                      last;
    } t_product_elem;

    // A row of the directed table is either a stream item or a register write.
    // For a register write, code is the register index and value holds the data.
    // Rows with has_value set carry the product of a 1x1x1 compute typed in by hand.
    typedef enum logic {STEP_ITEM, STEP_CFG} t_step_kind;

    typedef struct packed {
        t_step_kind                kind;
        logic [1:0]                code;
        logic [mm_pkg::POS_W-1:0]  row;
        logic [mm_pkg::POS_W-1:0]  col;
        logic [mm_pkg::ELEM_W-1:0] value;
        logic                      has_value;
        logic [mm_pkg::ELEM_W-1:0] product;
    } t_directed_step;

    localparam int N_DIRECTED = 27;

    t_directed_step directed_steps [N_DIRECTED] = '{
        // Zero sizes clamp to one, so the block works on 1x1 matrices here.
        '{STEP_CFG,  mm_pkg::CFG_ROWS_A,    3'd0, 3'd0, 32'h0000_0000, 1'b0, 32'h0},
        '{STEP_CFG,  mm_pkg::CFG_INNER_DIM, 3'd0, 3'd0, 32'h0000_0001, 1'b0, 32'h0},
        '{STEP_CFG,  mm_pkg::CFG_COLS_B,    3'd0, 3'd0, 32'h0000_0000, 1'b0, 32'h0},
        '{STEP_CFG,  CFG_UNUSED,            3'd0, 3'd0, 32'h0000_000F, 1'b0, 32'h0},
        // Largest positive squared saturates high.
        '{STEP_ITEM, mm_pkg::REQ_LOAD_A,    3'd0, 3'd0, 32'h7FFF_FFFF, 1'b0, 32'h0},
        '{STEP_ITEM, mm_pkg::REQ_LOAD_B,    3'd0, 3'd0, 32'h7FFF_FFFF, 1'b0, 32'h0},
        '{STEP_ITEM, mm_pkg::REQ_COMPUTE,   3'd7, 3'd7, 32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF},
        // Largest positive times most negative saturates low.
        '{STEP_ITEM, mm_pkg::REQ_LOAD_B,    3'd0, 3'd0, 32'h8000_0000, 1'b0, 32'h0},
        '{STEP_ITEM, mm_pkg::REQ_COMPUTE,   3'd0, 3'd0, 32'h0000_0000, 1'b1, 32'h8000_0000},
        // Most negative squared saturates high.
        '{STEP_ITEM, mm_pkg::REQ_LOAD_A,    3'd0, 3'd0, 32'h8000_0000, 1'b0, 32'h0},
        '{STEP_ITEM, mm_pkg::REQ_COMPUTE,   3'd0, 3'd0, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF},
        // One times minus one LSB stays exact.
        '{STEP_ITEM, mm_pkg::REQ_LOAD_A,    3'd0, 3'd0, 32'h0001_0000, 1'b0, 32'h0},
        '{STEP_ITEM, mm_pkg::REQ_LOAD_B,    3'd0, 3'd0, 32'hFFFF_FFFF, 1'b0, 32'h0},
        '{STEP_ITEM, mm_pkg::REQ_COMPUTE,   3'd0, 3'd0, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
        // Minus half an LSB truncates toward minus infinity, to minus one LSB.
        '{STEP_ITEM, mm_pkg::REQ_LOAD_A,    3'd0, 3'd0, 32'h0000_8000, 1'b0, 32'h0},
        '{STEP_ITEM, mm_pkg::REQ_COMPUTE,   3'd0, 3'd0, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
        // A write outside the configured size is still stored.
        '{STEP_ITEM, mm_pkg::REQ_LOAD_A,    3'd7, 3'd7, 32'h1234_5678, 1'b0, 32'h0},
        // Request kind three does nothing at all.
        '{STEP_ITEM, REQ_IGNORED,           3'd5, 3'd2, 32'hAAAA_AAAA, 1'b0, 32'h0},
        '{STEP_ITEM, mm_pkg::REQ_LOAD_A,    3'd0, 3'd0, 32'h0000_0000, 1'b0, 32'h0},
        '{STEP_ITEM, mm_pkg::REQ_COMPUTE,   3'd0, 3'd0, 32'h0000_0000, 1'b1, 32'h0000_0000},
        // A 2x2 by 2x1 product, checked against the predictor.
        '{STEP_CFG,  mm_pkg::CFG_ROWS_A,    3'd0, 3'd0, 32'h0000_0002, 1'b0, 32'h0},
        '{STEP_CFG,  mm_pkg::CFG_INNER_DIM, 3'd0, 3'd0, 32'h0000_0002, 1'b0, 32'h0},
        '{STEP_ITEM, mm_pkg::REQ_LOAD_A,    3'd0, 3'd1, 32'h0001_8000, 1'b0, 32'h0},
        '{STEP_ITEM, mm_pkg::REQ_LOAD_A,    3'd1, 3'd0, 32'hFFFF_0000, 1'b0, 32'h0},
        '{STEP_ITEM, mm_pkg::REQ_LOAD_A,    3'd1, 3'd1, 32'h0002_0000, 1'b0, 32'h0},
        '{STEP_ITEM, mm_pkg::REQ_LOAD_B,    3'd1, 3'd0, 32'h0003_0000, 1'b0, 32'h0},
        '{STEP_ITEM, mm_pkg::REQ_COMPUTE,   3'd3, 3'd4, 32'h5555_5555, 1'b0, 32'h0}
    };

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [mm_pkg::TDATA_W-1:0]    s_tdata;
    logic [mm_pkg::REQ_W-1:0]      s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [mm_pkg::TDATA_W-1:0]    m_tdata;
    logic                          m_tlast;
    logic                          i_cfg_we;
    logic [mm_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [mm_pkg::CFG_DATA_W-1:0] i_cfg_data;

    // Shadow copy of the block: both element stores, which entries were written,
    // and the three size registers as last written.
    logic signed [mm_pkg::ELEM_W-1:0] a_elems [mm_pkg::STORE_DEPTH];
    logic signed [mm_pkg::ELEM_W-1:0] b_elems [mm_pkg::STORE_DEPTH];
    bit                               a_written [mm_pkg::STORE_DEPTH];
    bit                               b_written [mm_pkg::STORE_DEPTH];
    logic [mm_pkg::CFG_DATA_W-1:0]    size_rows  = mm_pkg::CFG_DIM_RESET;
    logic [mm_pkg::CFG_DATA_W-1:0]    size_inner = mm_pkg::CFG_DIM_RESET;
    logic [mm_pkg::CFG_DATA_W-1:0]    size_cols  = mm_pkg::CFG_DIM_RESET;

    t_product_elem pending_products [$];

    int items_sent     = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;
    bit tx_burst       = 1'b0;
    bit rx_hold_req    = 1'b0;
    bit rx_holding     = 1'b0;

    matrix_multiply DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // A size register of zero counts as one, anything above the maximum as the maximum.
    function automatic int used_size(input logic [mm_pkg::CFG_DATA_W-1:0] raw);
        if (raw == '0) return 1;
        if (int'(raw) > mm_pkg::MAX_DIM) return mm_pkg::MAX_DIM;
        return int'(raw);
    endfunction

    function automatic void store_element(input logic [mm_pkg::REQ_W-1:0] req,
                                          input logic [mm_pkg::POS_W-1:0] row,
                                          input logic [mm_pkg::POS_W-1:0] col,
                                          input logic [mm_pkg::ELEM_W-1:0] value);
        int addr;
        addr = int'(row) * mm_pkg::MAX_DIM + int'(col);
        if (req == mm_pkg::REQ_LOAD_A) begin
            a_elems[addr]   = value;
            a_written[addr] = 1'b1;
        end else begin
            b_elems[addr]   = value;
            b_written[addr] = 1'b1;
        end
    endfunction

    // Every dot product is summed exactly over the full Q32.32 products, shifted down
    // by the fraction bits (an arithmetic shift floors) and then clipped to 32 bits.
    function automatic void multiply_stores();
        int                 n_rows;
        int                 n_inner;
        int                 n_cols;
        logic signed [71:0] dot;
        logic signed [55:0] floored;
        t_product_elem      elem;
        n_rows  = used_size(size_rows);
        n_inner = used_size(size_inner);
        n_cols  = used_size(size_cols);
        for (int r = 0; r < n_rows; r++) begin
            for (int c = 0; c < n_cols; c++) begin
                dot = '0;
                for (int k = 0; k < n_inner; k++) begin
                    dot = dot + a_elems[r * mm_pkg::MAX_DIM + k] *
                                b_elems[k * mm_pkg::MAX_DIM + c];
                end
                floored = 56'(dot >>> mm_pkg::FRAC_BITS);
                if (floored > Q_MAX) begin
                    elem.value = 32'h7FFF_FFFF;
                end else if (floored < Q_MIN) begin
                    elem.value = 32'h8000_0000;
                end else begin
                    elem.value = floored[mm_pkg::ELEM_W-1:0];
                end
                elem.row  = mm_pkg::POS_W'(r);
                elem.col  = mm_pkg::POS_W'(c);
                elem.last = (r == n_rows - 1) && (c == n_cols - 1);
                pending_products.push_back(elem);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Random choices
    // ------------------------------------------------------------------

    // Mostly short or no gaps, now and then a long one; none at all in a burst.
    function automatic int pick_gap();
        int sel;
        if (tx_burst) return 0;
        sel = $urandom_range(0, 19);
        if (sel < 11) return 0;
        if (sel < 17) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Small sizes keep the run short; zero and oversized values exercise the clamping.
    function automatic logic [mm_pkg::CFG_DATA_W-1:0] pick_size();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 14) return mm_pkg::CFG_DATA_W'($urandom_range(1, 3));
        if (sel < 16) return '0;
        if (sel < 19) return mm_pkg::CFG_DATA_W'($urandom_range(4, 8));
        return mm_pkg::CFG_DATA_W'($urandom_range(9, 15));
    endfunction

    // A mix of corner values, small Q16.16 values that stay clear of saturation,
    // and raw 32-bit patterns that toggle every bit.
    function automatic logic [mm_pkg::ELEM_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            case ($urandom_range(0, 4))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'hFFFF_FFFF;
                3:       return 32'h0001_0000;
                default: return 32'h0000_0000;
            endcase
        end
        if (sel < 5) return 32'(int'($urandom_range(0, 32'h80000)) - 32'h40000);
        return $urandom();
    endfunction

    // ------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------

    // Offers one item after a random gap and holds it until the block takes it.
    // tvalid stays high on return so that the next item can follow without a gap.
    task automatic send_item(input logic [mm_pkg::REQ_W-1:0]  req,
                             input logic [mm_pkg::POS_W-1:0]  row,
                             input logic [mm_pkg::POS_W-1:0]  col,
                             input logic [mm_pkg::ELEM_W-1:0] value,
                             input logic                      has_value,
                             input logic [mm_pkg::ELEM_W-1:0] product);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {2'b00, value, col, row};
        do @(posedge i_clk); while (!s_tready);
        if (req != REQ_IGNORED) items_sent++;
        case (req)
            mm_pkg::REQ_LOAD_A, mm_pkg::REQ_LOAD_B: store_element(req, row, col, value);
            mm_pkg::REQ_COMPUTE: begin
                if (has_value) begin
                    pending_products.push_back('{'0, '0, product, 1'b1});
                end else begin
                    multiply_stores();
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_random_load(input logic [mm_pkg::REQ_W-1:0] req,
                                    input int row, input int col);
        send_item(req, mm_pkg::POS_W'(row), mm_pkg::POS_W'(col), pick_value(), 1'b0, '0);
    endtask

    // Stops offering items and waits until every product element has come back,
    // then lets the block settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_products.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [mm_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [mm_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            mm_pkg::CFG_ROWS_A:    size_rows  = data;
            mm_pkg::CFG_INNER_DIM: size_inner = data;
            mm_pkg::CFG_COLS_B:    size_cols  = data;
            default: ;
        endcase
    endtask

    // Loads every entry that the next compute reads and that was never written,
    // since the stores hold no defined value until then.
    task automatic load_missing_operands();
        int n_rows;
        int n_inner;
        int n_cols;
        n_rows  = used_size(size_rows);
        n_inner = used_size(size_inner);
        n_cols  = used_size(size_cols);
        for (int r = 0; r < n_rows; r++) begin
            for (int k = 0; k < n_inner; k++) begin
                if (!a_written[r * mm_pkg::MAX_DIM + k]) begin
                    send_random_load(mm_pkg::REQ_LOAD_A, r, k);
                end
            end
        end
        for (int k = 0; k < n_inner; k++) begin
            for (int c = 0; c < n_cols; c++) begin
                if (!b_written[k * mm_pkg::MAX_DIM + c]) begin
                    send_random_load(mm_pkg::REQ_LOAD_B, k, c);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        int phase;
        logic [mm_pkg::CFG_DATA_W-1:0] rows_raw;
        logic [mm_pkg::CFG_DATA_W-1:0] inner_raw;
        logic [mm_pkg::CFG_DATA_W-1:0] cols_raw;
        i_rst_n    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: a size register is only ever written while the block is idle.
        foreach (directed_steps[n]) begin
            if (directed_steps[n].kind == STEP_CFG) begin
                wait_idle();
                write_register(directed_steps[n].code,
                               directed_steps[n].value[mm_pkg::CFG_DATA_W-1:0]);
            end else begin
                send_item(directed_steps[n].code, directed_steps[n].row, directed_steps[n].col,
                          directed_steps[n].value, directed_steps[n].has_value,
                          directed_steps[n].product);
            end
        end

        // Random part. Each phase drains the block, picks new sizes, and then runs a
        // few compute requests, each after some stray loads and the loads it needs.
        // A few phases use fixed sizes: one pinned at a mid size while the receiver
        // holds off, one at the full size, and one with every size above the maximum.
        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            wait_idle();
            rows_raw  = pick_size();
            inner_raw = pick_size();
            cols_raw  = pick_size();
            if (phase == 2) begin
                rows_raw  = 4'd4;
                inner_raw = 4'd4;
                cols_raw  = 4'd4;
            end else if (phase == 5) begin
                rows_raw  = mm_pkg::CFG_DIM_RESET;
                inner_raw = mm_pkg::CFG_DIM_RESET;
                cols_raw  = mm_pkg::CFG_DIM_RESET;
            end else if (phase == 7) begin
                rows_raw  = 4'd15;
                inner_raw = 4'd9;
                cols_raw  = 4'd12;
            end
            write_register(mm_pkg::CFG_ROWS_A, rows_raw);
            write_register(mm_pkg::CFG_INNER_DIM, inner_raw);
            write_register(mm_pkg::CFG_COLS_B, cols_raw);
            tx_burst = ($urandom_range(0, 3) == 0);

            repeat ((phase == 2) ? 3 : $urandom_range(1, 3)) begin
                repeat ($urandom_range(0, 5)) begin
                    if ($urandom_range(0, 6) == 0) begin
                        send_item(REQ_IGNORED, mm_pkg::POS_W'($urandom()),
                                  mm_pkg::POS_W'($urandom()), $urandom(), 1'b0, '0);
                    end else begin
                        send_random_load($urandom_range(0, 1) ? mm_pkg::REQ_LOAD_B
                                                              : mm_pkg::REQ_LOAD_A,
                                         $urandom_range(0, 7), $urandom_range(0, 7));
                    end
                end
                load_missing_operands();
                // The receiver stalls for a long stretch while more items are offered,
                // so the block backs up and drops its input ready.
                if (phase == 2) begin
                    rx_hold_req = 1'b1;
                    wait (rx_holding);
                end
                send_item(mm_pkg::REQ_COMPUTE, mm_pkg::POS_W'($urandom()),
                          mm_pkg::POS_W'($urandom()), $urandom(), 1'b0, '0);
            end
            phase++;
        end

        s_tvalid <= 1'b0;
        while (pending_products.size() != 0) @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random ready pattern with a long hold-off on request.
    // ------------------------------------------------------------------

    initial begin
        int sel;
        m_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_holding = 1'b1;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
                rx_holding  = 1'b0;
            end else begin
                sel = $urandom_range(0, 9);
                if (sel < 5) begin
                    m_tready <= 1'b1;
                    repeat ($urandom_range(1, 20)) @(posedge i_clk);
                end else if (sel < 8) begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end else if (sel < 9) begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(5, 40)) @(posedge i_clk);
                end else begin
                    m_tready <= 1'b1;
                    repeat ($urandom_range(50, 200)) @(posedge i_clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [mm_pkg::ELEM_W-1:0] want,
                                   input logic [mm_pkg::ELEM_W-1:0] got);
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
        mismatch_count++;
    endtask

    // Each accepted result item is compared with the oldest product element still owed.
    always @(posedge i_clk) begin : check_products
        t_product_elem want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_products.size() == 0) begin
                report_mismatch("unexpected item", '0, m_tdata[37:6]);
            end else begin
                want = pending_products.pop_front();
                if (m_tdata[2:0] !== want.row) report_mismatch("out_row", want.row, m_tdata[2:0]);
                if (m_tdata[5:3] !== want.col) report_mismatch("out_col", want.col, m_tdata[5:3]);
                if (m_tdata[37:6] !== want.value) begin
                    report_mismatch("product_value", want.value, m_tdata[37:6]);
                end
                if (m_tlast !== want.last) report_mismatch("last_elem", want.last, m_tlast);
            end
        end
    end

    // Ends the run when neither side nor the register port has moved for too long.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

### matrix_multiply.f
hdl/mm_pkg.sv
hdl/mm_store.sv
hdl/mm_mac.sv
hdl/matrix_multiply.sv
tb/sv/testbench.sv
